// File: sv/twist_slew_rate_limiter_core_defines.svh
// assertion macros for the twist slew-rate limiter
// used by the top level only, no other dependencies
`ifndef TWIST_SLEW_RATE_LIMITER_CORE_DEFINES_SVH
`define TWIST_SLEW_RATE_LIMITER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TWSRL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("twsrl assertion failed");
`define TWSRL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("twsrl assertion failed");
`else
`define TWSRL_ASSERT(lbl, prop)
`define TWSRL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: sv/twsrl_pkg.sv
// shared widths, codes and control structs of the twist slew-rate limiter
// no dependencies
package twsrl_pkg;

  localparam int VAL_W     = 24;
  localparam int STEP_W    = 23;
  localparam int MAG_W     = 24;
  localparam int INC_W     = VAL_W + 1;
  localparam int PROD_W    = STEP_W + MAG_W;
  localparam int DIV_CNT_W = $clog2(PROD_W);
  localparam int CFG_IDX_W = 8;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(3277);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_LIN = 8'd0,
    REG_DECEL_LIN = 8'd1,
    REG_ACCEL_ANG = 8'd2,
    REG_DECEL_ANG = 8'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul;
    logic cmp;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

// File: sv/twsrl_ifs.sv
// valid/ready channel interfaces: target word, result word, config write
// depends on twsrl_pkg
interface twsrl_tgt_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [twsrl_pkg::VAL_W-1:0]     target_vx;
  logic signed [twsrl_pkg::VAL_W-1:0]     target_vy;
  logic signed [twsrl_pkg::VAL_W-1:0]     target_wz;
  modport source (output valid, output target_vx, output target_vy, output target_wz,
                  input ready);
  modport sink (input valid, input target_vx, input target_vy, input target_wz,
                output ready);
endinterface

interface twsrl_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [twsrl_pkg::VAL_W-1:0]     out_vx;
  logic signed [twsrl_pkg::VAL_W-1:0]     out_vy;
  logic signed [twsrl_pkg::VAL_W-1:0]     out_wz;
  modport source (output valid, output out_vx, output out_vy, output out_wz,
                  input ready);
  modport sink (input valid, input out_vx, input out_vy, input out_wz,
                output ready);
endinterface

interface twsrl_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [twsrl_pkg::CFG_IDX_W-1:0]        index;
  logic [twsrl_pkg::STEP_W-1:0]           data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/twsrl_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on twsrl_pkg
module twsrl_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [twsrl_pkg::PROD_W-1:0]     num,
  input  logic [twsrl_pkg::MAG_W-1:0]      den,
  output logic                             busy,
  output logic [twsrl_pkg::PROD_W-1:0]     quo
);

  localparam int PW = twsrl_pkg::PROD_W;
  localparam int MW = twsrl_pkg::MAG_W;
  localparam int CW = twsrl_pkg::DIV_CNT_W;

  logic [MW-1:0] rem;
  logic [MW-1:0] rem_next;
  logic [PW-1:0] qsh;
  logic [MW-1:0] d;
  logic [CW-1:0] cnt;
  logic [MW:0]   trial;
  logic [MW:0]   diff;
  logic          ge;

  always_comb begin
    trial    = {rem, qsh[PW-1]};
    ge       = (trial >= {1'b0, d});
    diff     = trial - {1'b0, d};
    rem_next = ge ? diff[MW-1:0] : trial[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(PW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      qsh <= num;
      d   <= den;
    end else if (busy) begin
      rem <= rem_next;
      qsh <= {qsh[PW-2:0], ge};
    end
  end

  assign quo = qsh;

endmodule

// File: sv/twsrl_ctrl.sv
// sequencer: capture, increments, products, compare, divide, emit
// depends on twsrl_pkg
module twsrl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  twsrl_pkg::stat_t  stat,
  output logic              in_ready,
  output twsrl_pkg::ctl_t   ctl
);

  twsrl_pkg::state_t state;
  twsrl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= twsrl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      twsrl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = twsrl_pkg::ST_PREP;
        end
      end
      twsrl_pkg::ST_PREP: begin
        ctl.prep   = 1'b1;
        state_next = twsrl_pkg::ST_MUL;
      end
      twsrl_pkg::ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = twsrl_pkg::ST_CMP;
      end
      twsrl_pkg::ST_CMP: begin
        ctl.cmp    = 1'b1;
        state_next = stat.need_div ? twsrl_pkg::ST_DIV : twsrl_pkg::ST_OUT;
      end
      twsrl_pkg::ST_DIV: begin
        if (!stat.div_busy) begin
          state_next = twsrl_pkg::ST_OUT;
        end
      end
      twsrl_pkg::ST_OUT: begin
        if (stat.out_free) begin
          ctl.emit   = 1'b1;
          state_next = twsrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = twsrl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/twsrl_dp.sv
// datapath: step registers, last command, products, divider, clamp, result register
// depends on twsrl_pkg, twsrl_ifs, twsrl_div
module twsrl_dp (
  input  logic              clk,
  input  logic              rst,
  input  twsrl_pkg::ctl_t   ctl,
  output twsrl_pkg::stat_t  stat,
  twsrl_tgt_if.sink         cmd,
  twsrl_out_if.source       res,
  twsrl_cfg_if.sink         cfg
);

  localparam int VW = twsrl_pkg::VAL_W;
  localparam int SW = twsrl_pkg::STEP_W;
  localparam int MW = twsrl_pkg::MAG_W;
  localparam int IW = twsrl_pkg::INC_W;
  localparam int PW = twsrl_pkg::PROD_W;

  localparam logic signed [VW+1:0] SUM_MAX = (VW+2)'((1 << (VW - 1)) - 1);
  localparam logic signed [VW+1:0] SUM_MIN = -(VW+2)'(1 << (VW - 1));

  // step registers
  logic [SW-1:0] accel_lin;
  logic [SW-1:0] decel_lin;
  logic [SW-1:0] accel_ang;
  logic [SW-1:0] decel_ang;

  logic signed [VW-1:0] prev_vx, prev_vy, prev_wz;
  logic signed [VW-1:0] tx, ty, tw;
  logic signed [IW-1:0] dx, dy, dw;
  logic [MW-1:0]        ax, ay, aw;
  logic [SW-1:0]        lv, ly, lw;
  logic [PW-1:0]        pa, pb;
  logic                 sel_v;
  logic                 use_div;

  logic signed [IW-1:0] dx_c, dy_c, dw_c;
  logic                 pa_lt;
  logic                 need_div;
  logic [PW-1:0]        div_num;
  logic [MW-1:0]        div_den;
  logic                 div_busy;
  logic [PW-1:0]        quo;
  logic [MW-1:0]        q_sat;
  logic [MW-1:0]        lv_f, ly_f, lw_f;
  logic signed [VW-1:0] ox, oy, ow;
  logic                 out_valid;

  function automatic logic [MW-1:0] mag(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] n;
    n   = -v;
    mag = v[IW-1] ? n[MW-1:0] : v[MW-1:0];
  endfunction

  function automatic logic rising(input logic signed [VW-1:0] tgt,
                                  input logic signed [VW-1:0] last,
                                  input logic signed [IW-1:0] inc);
    logic inc_pos;
    logic last_pos;
    inc_pos  = !inc[IW-1] && (inc != '0);
    last_pos = !last[VW-1] && (last != '0);
    rising   = (tgt != '0) && ((inc_pos && last_pos) || (inc[IW-1] && last[VW-1]));
  endfunction

  function automatic logic signed [VW-1:0] limit_axis(input logic signed [VW-1:0] last,
                                                      input logic signed [VW-1:0] tgt,
                                                      input logic neg,
                                                      input logic [MW-1:0] mg,
                                                      input logic [MW-1:0] lim);
    logic signed [VW+1:0] lim_s;
    logic signed [VW+1:0] r;
    lim_s = signed'({2'b00, lim});
    r     = neg ? (last - lim_s) : (last + lim_s);
    if (mg <= lim) begin
      limit_axis = tgt;
    end else if (r > SUM_MAX) begin
      limit_axis = SUM_MAX[VW-1:0];
    end else if (r < SUM_MIN) begin
      limit_axis = SUM_MIN[VW-1:0];
    end else begin
      limit_axis = r[VW-1:0];
    end
  endfunction

  // config writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_lin <= twsrl_pkg::STEP_RESET;
      decel_lin <= twsrl_pkg::STEP_RESET;
      accel_ang <= twsrl_pkg::STEP_RESET;
      decel_ang <= twsrl_pkg::STEP_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == twsrl_pkg::REG_ACCEL_LIN) begin
        accel_lin <= cfg.data;
      end
      if (cfg.index == twsrl_pkg::REG_DECEL_LIN) begin
        decel_lin <= cfg.data;
      end
      if (cfg.index == twsrl_pkg::REG_ACCEL_ANG) begin
        accel_ang <= cfg.data;
      end
      if (cfg.index == twsrl_pkg::REG_DECEL_ANG) begin
        decel_ang <= cfg.data;
      end
    end
  end

  // increments
  always_comb begin
    dx_c = IW'(tx) - IW'(prev_vx);
    dy_c = IW'(ty) - IW'(prev_vy);
    dw_c = IW'(tw) - IW'(prev_wz);
  end

  // coupling decision
  always_comb begin
    pa_lt    = (pa < pb);
    need_div = pa_lt || (ax != '0);
    div_num  = pa_lt ? pa : pb;
    div_den  = pa_lt ? aw : ax;
  end

  twsrl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.cmp && need_div),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  // final limits and clamp
  always_comb begin
    q_sat = (|quo[PW-1:MW]) ? '1 : quo[MW-1:0];
    lv_f  = (use_div && sel_v)  ? q_sat : MW'(lv);
    lw_f  = (use_div && !sel_v) ? q_sat : MW'(lw);
    ly_f  = MW'(ly);
    ox    = limit_axis(prev_vx, tx, dx[IW-1], ax, lv_f);
    oy    = limit_axis(prev_vy, ty, dy[IW-1], ay, ly_f);
    ow    = limit_axis(prev_wz, tw, dw[IW-1], aw, lw_f);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tx <= cmd.target_vx;
      ty <= cmd.target_vy;
      tw <= cmd.target_wz;
    end
    if (ctl.prep) begin
      dx <= dx_c;
      dy <= dy_c;
      dw <= dw_c;
      ax <= mag(dx_c);
      ay <= mag(dy_c);
      aw <= mag(dw_c);
      lv <= rising(tx, prev_vx, dx_c) ? accel_lin : decel_lin;
      ly <= rising(ty, prev_vy, dy_c) ? accel_lin : decel_lin;
      lw <= rising(tw, prev_wz, dw_c) ? accel_ang : decel_ang;
    end
    if (ctl.mul) begin
      pa <= lw * ax;
      pb <= aw * lv;
    end
    if (ctl.cmp) begin
      sel_v   <= pa_lt;
      use_div <= need_div;
    end
    if (ctl.emit) begin
      res.out_vx <= ox;
      res.out_vy <= oy;
      res.out_wz <= ow;
    end
  end

  // last command and result word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_vx   <= '0;
      prev_vy   <= '0;
      prev_wz   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.emit) begin
        prev_vx   <= ox;
        prev_vy   <= oy;
        prev_wz   <= ow;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid     = out_valid;
  assign stat.need_div = need_div;
  assign stat.div_busy = div_busy;
  assign stat.out_free = !out_valid || res.ready;

endmodule

// File: sv/twist_slew_rate_limiter_core.sv
// top level of the twist slew-rate limiter: sequencer plus datapath
// depends on twsrl_pkg, twsrl_ifs, twsrl_ctrl, twsrl_dp and the defines header
//
// channel   role    word
// cmd       sink    target_vx, target_vy, target_wz (signed 24 bit)
// res       source  out_vx, out_vy, out_wz (signed 24 bit)
// cfg       sink    index (8 bit), data (23 bit step value), always ready
//
// one word at a time: accept, then prep, multiply and compare, then emit the result;
// when a limit is rescaled, the 47-bit one-bit-per-cycle divider runs before emit
// the result register frees the sequencer; emit stalls only if a result is still waiting
// synchronous reset clears the last command to zero and the steps to 3277
`include "twist_slew_rate_limiter_core_defines.svh"
module twist_slew_rate_limiter_core (
  input  logic         clk,
  input  logic         rst,
  twsrl_tgt_if.sink    cmd,
  twsrl_out_if.source  res,
  twsrl_cfg_if.sink    cfg
);

  twsrl_pkg::ctl_t  ctl;
  twsrl_pkg::stat_t stat;
  logic             in_ready;

  twsrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .stat     (stat),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  assign cmd.ready = in_ready;

  twsrl_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .stat (stat),
    .cmd  (cmd),
    .res  (res),
    .cfg  (cfg)
  );

  `TWSRL_ASSERT(a_idle_no_div, cmd.ready |-> !stat.div_busy)
  `TWSRL_ASSERT(a_accept_then_busy, (cmd.valid && cmd.ready) |=> !cmd.ready)
  `TWSRL_ASSERT(a_emit_into_free, ctl.emit |-> (!res.valid || res.ready))
  `TWSRL_ASSERT_ALWAYS(a_one_command, $onehot0(ctl))

endmodule
